>>> hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types for the twin prime classifier
// Result codes and the status bundles passed between the sequencer levels.
// ----------------------------------------------------------------------------
package tpc_pkg;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_BOTH  = 2'd1,
		KIND_TWINS = 2'd2
	} tpc_kind_t;

	// remainder unit status
	typedef struct packed {
		logic done;
		logic zero;
	} tpc_rem_res_t;

	// primality tester status
	typedef struct packed {
		logic done;
		logic prime;
	} tpc_prime_res_t;

endpackage

>>> hdl/tpc_rem.sv
// ----------------------------------------------------------------------------
// tpc_rem: bit-serial remainder unit
// Restoring division of n by d, one dividend bit per cycle, MSB first.
// Reports whether the remainder is zero once all VALUE_WIDTH dividend bits are in.
// ----------------------------------------------------------------------------
module tpc_rem #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [VALUE_WIDTH-1:0]    n,
	input  logic [VALUE_WIDTH-1:0]    d,
	output tpc_pkg::tpc_rem_res_t     res
);
	import tpc_pkg::*;

	localparam int CW = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] shreg_q;
	logic [VALUE_WIDTH-1:0] r_q;
	logic [CW-1:0]          cnt_q;
	logic                   run_q;
	tpc_rem_res_t           res_q;

	logic [VALUE_WIDTH:0]   rt;
	logic [VALUE_WIDTH:0]   diff;
	logic [VALUE_WIDTH-1:0] r_next;

	assign rt     = {r_q, shreg_q[VALUE_WIDTH-1]};
	assign diff   = rt - {1'b0, d};
	assign r_next = diff[VALUE_WIDTH] ? rt[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			cnt_q      <= '0;
			res_q.done <= 1'b0;
			res_q.zero <= 1'b0;
		end else begin
			res_q.done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(VALUE_WIDTH - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q      <= 1'b0;
					res_q.done <= 1'b1;
					res_q.zero <= (r_next == '0);
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= n;
			r_q     <= '0;
		end else if (run_q) begin
			shreg_q <= {shreg_q[VALUE_WIDTH-2:0], 1'b0};
			r_q     <= r_next;
		end
	end

	assign res = res_q;

endmodule

>>> hdl/tpc_prime.sv
// ----------------------------------------------------------------------------
// tpc_prime: trial division sequencer
// Screens trivial cases, then walks odd divisors d while d*d <= n,
// tracking d*d incrementally and handing each division to tpc_rem.
// ----------------------------------------------------------------------------
module tpc_prime #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [VALUE_WIDTH-1:0]    value,
	output tpc_pkg::tpc_prime_res_t   res
);
	import tpc_pkg::*;

	typedef enum logic [1:0] {
		P_IDLE,
		P_CHECK,
		P_DIV
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [VALUE_WIDTH:0]   sq_q;
	logic                   rem_start_q;
	tpc_prime_res_t         res_q;
	tpc_rem_res_t           rem_res;

	logic [VALUE_WIDTH+2:0] sq_step;

	// (d+2)^2 = d^2 + 4d + 4
	assign sq_step = {2'b00, sq_q} + {1'b0, d_q, 2'b00} + (VALUE_WIDTH+3)'(4);

	tpc_rem #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (rem_start_q),
		.n     (n_q),
		.d     (d_q),
		.res   (rem_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= P_IDLE;
			rem_start_q <= 1'b0;
			res_q.done  <= 1'b0;
			res_q.prime <= 1'b0;
		end else begin
			res_q.done  <= 1'b0;
			rem_start_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						if (value[VALUE_WIDTH-1] || value[VALUE_WIDTH-1:1] == '0) begin
							res_q.done  <= 1'b1;
							res_q.prime <= 1'b0;
						end else if (value == VALUE_WIDTH'(2)) begin
							res_q.done  <= 1'b1;
							res_q.prime <= 1'b1;
						end else if (!value[0]) begin
							res_q.done  <= 1'b1;
							res_q.prime <= 1'b0;
						end else begin
							state_q <= P_CHECK;
						end
					end
				end
				P_CHECK: begin
					if (sq_q > {1'b0, n_q}) begin
						res_q.done  <= 1'b1;
						res_q.prime <= 1'b1;
						state_q     <= P_IDLE;
					end else begin
						rem_start_q <= 1'b1;
						state_q     <= P_DIV;
					end
				end
				P_DIV: begin
					if (rem_res.done) begin
						if (rem_res.zero) begin
							res_q.done  <= 1'b1;
							res_q.prime <= 1'b0;
							state_q     <= P_IDLE;
						end else begin
							state_q <= P_CHECK;
						end
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && start) begin
			n_q  <= value;
			d_q  <= VALUE_WIDTH'(3);
			sq_q <= (VALUE_WIDTH+1)'(9);
		end else if (state_q == P_DIV && rem_res.done) begin
			d_q  <= d_q + VALUE_WIDTH'(2);
			sq_q <= sq_step[VALUE_WIDTH:0];
		end
	end

	assign res = res_q;

endmodule

>>> hdl/twin_prime_classifier.sv
// ----------------------------------------------------------------------------
// twin_prime_classifier: twin prime classifier, top level
// Classifies a pair of signed values as not both prime, both prime or twin primes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: first_value and second_value are taken at a rising edge
//   with start high and busy low. busy stays high until the result.
//   Result beat: kind is valid for the single cycle in which done is high;
//   the receiver cannot hold it off. busy falls in that same cycle, so a
//   new pair may be started while the result is on the ports.
//   Operation: each value is tested in turn by one shared trial division
//   unit; the second is skipped when the first is not prime. Trivial
//   values are screened out directly; otherwise odd divisors are tried,
//   up to about sqrt(n)/2 of them, each by the bit-serial remainder, one
//   dividend bit per cycle, which sets the run time.
//   Items are handled one at a time.
//   Reset: arst_n clears all control state; the block comes up idle.
// ----------------------------------------------------------------------------
module twin_prime_classifier #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] first_value,
	input  logic signed [VALUE_WIDTH-1:0] second_value,
	output logic                          done,
	output logic [1:0]                    kind
);
	import tpc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TEST_A,
		S_TEST_B
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic                   sel_q;
	logic                   pstart_q;
	logic                   busy_q;
	logic                   done_q;
	tpc_kind_t              kind_q;
	tpc_prime_res_t         pres;

	logic [VALUE_WIDTH-1:0] test_value;
	logic                   twins;

	assign test_value = sel_q ? b_q : a_q;
	assign twins = ({1'b0, a_q} == {1'b0, b_q} + (VALUE_WIDTH+1)'(2)) ||
	               ({1'b0, b_q} == {1'b0, a_q} + (VALUE_WIDTH+1)'(2));

	tpc_prime #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_prime (
		.clk   (clk),
		.arst_n(arst_n),
		.start (pstart_q),
		.value (test_value),
		.res   (pres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_q    <= 1'b0;
			pstart_q <= 1'b0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			kind_q   <= KIND_NONE;
		end else begin
			done_q   <= 1'b0;
			pstart_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						sel_q    <= 1'b0;
						pstart_q <= 1'b1;
						busy_q   <= 1'b1;
						state_q  <= S_TEST_A;
					end
				end
				S_TEST_A: begin
					if (pres.done) begin
						if (pres.prime) begin
							sel_q    <= 1'b1;
							pstart_q <= 1'b1;
							state_q  <= S_TEST_B;
						end else begin
							kind_q  <= KIND_NONE;
							done_q  <= 1'b1;
							busy_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				S_TEST_B: begin
					if (pres.done) begin
						if (!pres.prime) begin
							kind_q <= KIND_NONE;
						end else if (twins) begin
							kind_q <= KIND_TWINS;
						end else begin
							kind_q <= KIND_BOTH;
						end
						done_q  <= 1'b1;
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// operand capture, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			a_q <= first_value;
			b_q <= second_value;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign kind = kind_q;

endmodule

>>> hdl/tpc_chk.sv
// ----------------------------------------------------------------------------
// tpc_chk: port checker for the twin prime classifier
// Watches the command and result beats on the top level's ports.
// ----------------------------------------------------------------------------
module tpc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] kind
);
	import tpc_pkg::*;

	// a code that means nothing is never shown
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (kind == KIND_NONE || kind == KIND_BOTH || kind == KIND_TWINS))
		else $error("tpc_chk: illegal kind code");

	// an accepted beat holds the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("tpc_chk: not busy after accept");

	// busy only ends with a result beat
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("tpc_chk: busy dropped without result");

	// no result while an item is still in work
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("tpc_chk: result while busy");

	// one result per item, never two in a row
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("tpc_chk: repeated result");

endmodule

bind twin_prime_classifier tpc_chk u_tpc_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.kind  (kind)
);
